/* src/assert_macros.svh */
// Assertion macros shared by the checker files of this project.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/sakv_pkg.sv */
// Package for the set-associative key-value table.
// Holds field widths, operation and status codes, and the word types.
`timescale 1ns / 1ps

package sakv_pkg;

	// Default geometry of the table.
	localparam int SAKV_SETS = 64;
	localparam int SAKV_WAYS = 4;

	// Field widths.
	localparam int KEY_W     = 64;
	localparam int VAL_W     = 64;
	localparam int ACT_W     = 2;
	localparam int ST_W      = 3;

	// Operation codes.
	localparam logic [ACT_W-1:0] ACT_PUT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_GET = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DEL = 2'd2;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [ST_W-1:0] ST_CONFLICT  = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
	localparam logic [ST_W-1:0] ST_ZERO      = 3'd4;

	// Request word.
	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	// Response word.
	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [VAL_W-1:0] read_value;
	} rsp_t;

	// One slot of the table as stored in memory.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

/* src/set_assoc_key_value_table.sv */
// Top level of the set-associative key-value table: sequencer, slot compare unit and table RAM.
// Depends on sakv_pkg, sakv_ram and sakv_set_index.
`timescale 1ns / 1ps

// A table of SETS sets with WAYS slots each, one 64-bit key and one 64-bit value per slot,
// kept in a single RAM of SETS*WAYS words. After reset the block first clears the RAM, one
// slot per cycle, and accepts no request until every slot is cleared. Requests are then
// handled one at a time. A request rejected on its fields (zero key, zero value on put,
// unused action) skips the table and goes straight to the response register. Any other
// request examines 1 to WAYS ways of its set, stopping at the first way that decides: the
// ways are read one by one through the single RAM read port and checked by one key/value
// compare unit. When SETS is not a power of two the set number is found by a fold and
// reciprocal-multiply remainder pipeline. A finished response waits in an output register,
// and the next request may be accepted meanwhile.
module set_assoc_key_value_table import sakv_pkg::*; #(
	parameter int SETS = SAKV_SETS,
	parameter int WAYS = SAKV_WAYS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int DEPTH  = SETS * WAYS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W  = $clog2(SETS);
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_INDEX = 6'b000100,
		S_READ  = 6'b001000,
		S_CMP   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t             state_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [WAY_W-1:0]   way_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [ACT_W-1:0]   act_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;
	logic [ADDR_W-1:0]  base_q;
	logic [ST_W-1:0]    res_status_q;
	logic [VAL_W-1:0]   res_value_q;

	logic               acc;
	logic               rsp_free;
	logic               rsp_load;
	logic               req_is_put;
	logic               req_is_find;
	logic               req_bad;
	logic [ST_W-1:0]    req_status;

	logic               idx_start;
	logic               idx_done;
	logic [IDX_W-1:0]   idx;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	slot_t              ram_wdata;
	logic               ram_re;
	logic [ADDR_W-1:0]  slot_addr;
	slot_t              ram_rdata;

	logic               key_eq;
	logic               val_eq;
	logic               val_zero;
	logic               slot_empty;
	logic               live;
	logic               last_way;
	logic               act_put;
	logic               act_del;
	logic               cmp_finish;
	logic [ST_W-1:0]    cmp_status;
	logic [VAL_W-1:0]   cmp_value;

	// Handshake.
	assign req_stall = (state_q != S_IDLE);
	assign acc       = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = (state_q == S_DONE) && rsp_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Field checks on the incoming word; bad requests skip the table.
	always_comb begin
		req_is_put  = (req.action == ACT_PUT);
		req_is_find = req.action inside {ACT_GET, ACT_DEL};
		req_bad     = !(req_is_put || req_is_find)
			|| (req_is_put && ((req.key == '0) || (req.value == '0)))
			|| (req_is_find && (req.key == '0));
		req_status  = (req_is_put && req_bad) ? ST_ZERO : ST_NOT_FOUND;
	end

	assign idx_start = acc && !req_bad;

	sakv_set_index #(
		.SETS (SETS)
	) u_set_index (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (idx_start),
		.key    (req.key),
		.done   (idx_done),
		.idx    (idx)
	);

	// Shared slot compare unit.
	always_comb begin
		act_put    = (act_q == ACT_PUT);
		act_del    = (act_q == ACT_DEL);
		key_eq     = (ram_rdata.key == key_q);
		val_eq     = (ram_rdata.value == val_q);
		val_zero   = (ram_rdata.value == '0);
		slot_empty = (ram_rdata.key == '0) || val_zero;
		live       = key_eq && !val_zero;
		last_way   = (way_q == WAY_W'(WAYS - 1));
		if (act_put) begin
			cmp_finish = key_eq || slot_empty || last_way;
			cmp_value  = '0;
			if (key_eq) begin
				cmp_status = val_eq ? ST_OK : ST_CONFLICT;
			end else if (slot_empty) begin
				cmp_status = ST_OK;
			end else begin
				cmp_status = ST_FULL;
			end
		end else begin
			cmp_finish = live || last_way;
			cmp_status = live ? ST_OK : ST_NOT_FOUND;
			cmp_value  = live ? ram_rdata.value : '0;
		end
	end

	// RAM ports: clearing pass, slot reads, and the one write, if any, that ends a put or delete.
	assign slot_addr = base_q + ADDR_W'(way_q);
	assign ram_re    = (state_q == S_READ);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_addr;
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end else if (state_q == S_CMP) begin
			if (act_put && !key_eq && slot_empty) begin
				ram_we    = 1'b1;
				ram_wdata = '{key: key_q, value: val_q};
			end else if (act_del && live) begin
				ram_we = 1'b1;
			end
		end
	end

	sakv_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (slot_addr),
		.rdata (ram_rdata)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			way_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						state_q <= req_bad ? S_DONE : S_INDEX;
					end
				end
				S_INDEX: begin
					if (idx_done) begin
						way_q   <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (cmp_finish) begin
						state_q <= S_DONE;
					end else begin
						way_q   <= way_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// Request, result and response words.
	always_ff @(posedge clk) begin
		if (acc) begin
			act_q        <= req.action;
			key_q        <= req.key;
			val_q        <= req.value;
			res_status_q <= req_status;
			res_value_q  <= '0;
		end
		if ((state_q == S_INDEX) && idx_done) begin
			base_q <= ADDR_W'(idx) * ADDR_W'(WAYS);
		end
		if (state_q == S_CMP) begin
			res_status_q <= cmp_status;
			res_value_q  <= cmp_value;
		end
		if (rsp_load) begin
			rsp_q <= '{status: res_status_q, read_value: res_value_q};
		end
	end

endmodule

/* src/sakv_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on sakv_pkg for default sizes only.
`timescale 1ns / 1ps

module sakv_ram import sakv_pkg::*; #(
	parameter int WIDTH = SLOT_W,
	parameter int DEPTH = SAKV_SETS * SAKV_WAYS
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/sakv_set_index.sv */
// Set index unit: reduces a key to its set number, key modulo SETS.
// Depends on sakv_pkg; a power-of-two SETS takes the registered low key bits, otherwise a five-stage fold pipeline.
`timescale 1ns / 1ps

module sakv_set_index import sakv_pkg::*; #(
	parameter int SETS = SAKV_SETS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [KEY_W-1:0]          key,
	output logic                      done,
	output logic [$clog2(SETS)-1:0]   idx
);

	localparam int IDX_W = $clog2(SETS);
	localparam bit POW2  = ((SETS & (SETS - 1)) == 0);

	generate
		if (POW2) begin : g_pow2
			logic             done_q;
			logic [IDX_W-1:0] idx_q;

			// The low key bits are the set number.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					idx_q <= key[IDX_W-1:0];
				end
			end

			assign done = done_q;
			assign idx  = idx_q;
		end else begin : g_fold
			localparam int CHUNK_W = 16;
			localparam int PROD_W  = CHUNK_W + IDX_W;
			localparam int FOLD_W  = PROD_W + 2;
			localparam int QUO_W   = FOLD_W - 1;
			localparam int MUL_W   = FOLD_W + QUO_W;
			localparam longint unsigned M1    = (64'd1 << CHUNK_W) % 64'(SETS);
			localparam longint unsigned M2    = (64'd1 << (2 * CHUNK_W)) % 64'(SETS);
			localparam longint unsigned M3    = (64'd1 << (3 * CHUNK_W)) % 64'(SETS);
			localparam longint unsigned RECIP = (64'd1 << FOLD_W) / 64'(SETS);

			logic               vld_s1;
			logic               vld_s2;
			logic               vld_s3;
			logic               vld_s4;
			logic               done_q;
			logic [KEY_W-1:0]   key_s1;
			logic [FOLD_W-1:0]  fold_s2;
			logic [FOLD_W-1:0]  fold_s3;
			logic [QUO_W-1:0]   quo_s3;
			logic [IDX_W:0]     diff_s4;
			logic [IDX_W-1:0]   rem_q;
			logic [FOLD_W-1:0]  fold;
			logic [MUL_W-1:0]   recip_prod;
			logic [FOLD_W-1:0]  diff;
			logic [IDX_W-1:0]   reduced;

			// Fold the four 16-bit key chunks with their weights modulo SETS.
			assign fold = FOLD_W'(key_s1[CHUNK_W-1:0])
				+ FOLD_W'(PROD_W'(key_s1[2*CHUNK_W-1:CHUNK_W]) * PROD_W'(M1))
				+ FOLD_W'(PROD_W'(key_s1[3*CHUNK_W-1:2*CHUNK_W]) * PROD_W'(M2))
				+ FOLD_W'(PROD_W'(key_s1[4*CHUNK_W-1:3*CHUNK_W]) * PROD_W'(M3));

			// The reciprocal estimate of the quotient is exact or one too small.
			assign recip_prod = MUL_W'(fold_s2) * MUL_W'(RECIP);
			assign diff       = fold_s3 - FOLD_W'(quo_s3) * FOLD_W'(SETS);

			// One compare and subtract brings the remainder below SETS.
			assign reduced = (diff_s4 >= (IDX_W + 1)'(SETS))
				? IDX_W'(diff_s4 - (IDX_W + 1)'(SETS)) : diff_s4[IDX_W-1:0];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s1 <= 1'b0;
					vld_s2 <= 1'b0;
					vld_s3 <= 1'b0;
					vld_s4 <= 1'b0;
					done_q <= 1'b0;
				end else begin
					vld_s1 <= start;
					vld_s2 <= vld_s1;
					vld_s3 <= vld_s2;
					vld_s4 <= vld_s3;
					done_q <= vld_s4;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_s1 <= key;
				end
				if (vld_s1) begin
					fold_s2 <= fold;
				end
				if (vld_s2) begin
					quo_s3  <= recip_prod[MUL_W-1:FOLD_W];
					fold_s3 <= fold_s2;
				end
				if (vld_s3) begin
					diff_s4 <= diff[IDX_W:0];
				end
				if (vld_s4) begin
					rem_q <= reduced;
				end
			end

			assign done = done_q;
			assign idx  = rem_q;
		end
	endgenerate

endmodule

/* src/sakv_checker.sv */
// Port-level checker for the set-associative key-value table, bound to the top level.
// Depends on sakv_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sakv_checker import sakv_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// A stalled response word stays put.
	`CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response changed while stalled")

	// Only a successful get or delete carries a value.
	`CHK_NOW(a_value_only_ok, rsp_valid && (rsp.status != ST_OK), rsp.read_value == '0, "value on a failed request")

	// The block works on one request at a time.
	`CHK_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "request accepted while busy")

endmodule

bind set_assoc_key_value_table sakv_checker u_sakv_checker (.*);

/* bench/tb_top.sv */
// Self-checking bench for the set-associative key-value table.
// Depends on sakv_pkg and set_assoc_key_value_table; keeps its own copy of the slot store.
`timescale 1ns / 1ps

module tb_top;
	import sakv_pkg::*;

	localparam int SETS  = SAKV_SETS;
	localparam int WAYS  = SAKV_WAYS;
	localparam int SLOTS = SETS * WAYS;
	localparam int POOL  = 16;
	localparam int TAIL  = 40;

	// Action code that the table does not use; it must answer not found.
	localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Shadow copy of the slot store, indexed as set*WAYS + way.
	logic [KEY_W-1:0] shadow_key [SLOTS];
	logic [VAL_W-1:0] shadow_val [SLOTS];

	rsp_t pending_rsp [$];
	rsp_t want_rsp;
	bit steady = 1'b0;
	int n_sent = 0;
	int n_checked = 0;
	int n_errors = 0;
	int status_seen [8];

	set_assoc_key_value_table #(.SETS(SETS), .WAYS(WAYS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	// A 64-bit random word.
	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// A random nonzero key that falls into the given set.
	function automatic logic [KEY_W-1:0] set_key(input int set_no);
		logic [KEY_W-1:0] k;
		k = rand_word();
		k = k - (k % SETS) + KEY_W'(set_no);
		if (k == '0)
			k[KEY_W-1] = 1'b1;
		return k;
	endfunction

	// Apply one request word to the shadow store and return the response it must produce.
	function automatic rsp_t table_apply(input req_t w);
		rsp_t r;
		int base;
		int hit;
		bit done;
		r.status = ST_NOT_FOUND;
		r.read_value = '0;
		base = int'(w.key % SETS) * WAYS;
		hit = -1;
		done = 1'b0;
		case (w.action)
			ACT_PUT: begin
				if (w.key == '0 || w.value == '0) begin
					r.status = ST_ZERO;
				end else begin
					// The first way with an equal key or an empty slot decides; an empty slot takes the pair.
					r.status = ST_FULL;
					for (int i = 0; i < WAYS && !done; i++) begin
						if (shadow_key[base + i] == w.key) begin
							r.status = (shadow_val[base + i] == w.value) ? ST_OK : ST_CONFLICT;
							done = 1'b1;
						end else if (shadow_key[base + i] == '0 || shadow_val[base + i] == '0) begin
							shadow_key[base + i] = w.key;
							shadow_val[base + i] = w.value;
							r.status = ST_OK;
							done = 1'b1;
						end
					end
				end
			end
			ACT_GET, ACT_DEL: begin
				// Only a slot with a matching key and a live value counts as a hit.
				if (w.key != '0) begin
					for (int i = 0; i < WAYS && hit < 0; i++)
						if (shadow_key[base + i] == w.key && shadow_val[base + i] != '0)
							hit = base + i;
				end
				if (hit >= 0) begin
					r.status = ST_OK;
					r.read_value = shadow_val[hit];
					if (w.action == ACT_DEL) begin
						shadow_key[hit] = '0;
						shadow_val[hit] = '0;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Offer one request word, wait for it to be taken and record its expected response.
	task automatic send_word(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		req_t w;
		w.action = act;
		w.key = k;
		w.value = v;
		while (!steady && $urandom_range(99) < 6) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsp.push_back(table_apply(w));
		n_sent++;
	endtask

	// Stop sending and hold off until every outstanding response has come back.
	task automatic wait_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Zero keys, zero values, the unused action and a lookup in an empty set.
	task automatic test_field_rejects();
		send_word(ACT_PUT, '0, rand_word());
		send_word(ACT_PUT, set_key(5), '0);
		send_word(ACT_PUT, '0, '0);
		send_word(ACT_GET, '0, rand_word());
		send_word(ACT_DEL, '0, rand_word());
		send_word(ACT_NOP, set_key(5), rand_word());
		send_word(ACT_GET, set_key(5), '0);
	endtask

	// Fresh put, repeated put with equal value, put with a different value, then get.
	task automatic test_put_rules(output logic [KEY_W-1:0] first_key);
		logic [VAL_W-1:0] v1;
		first_key = set_key(9);
		v1 = rand_word() | 64'h1;
		send_word(ACT_PUT, first_key, v1);
		send_word(ACT_PUT, first_key, v1);
		send_word(ACT_PUT, first_key, v1 ^ 64'h8000_0000_0000_0002);
		send_word(ACT_GET, first_key, '0);
	endtask

	// Fill the set, overflow it, then free the first way so that a later key lands ahead
	// of its own older copy, and check which copy lookups see.
	task automatic test_set_reuse(input logic [KEY_W-1:0] first_key);
		logic [KEY_W-1:0] k3;
		k3 = set_key(9);
		send_word(ACT_PUT, set_key(9), rand_word());
		send_word(ACT_PUT, k3, rand_word());
		send_word(ACT_PUT, set_key(9), rand_word());
		send_word(ACT_PUT, set_key(9), rand_word());
		send_word(ACT_DEL, first_key, '0);
		send_word(ACT_PUT, k3, rand_word());
		send_word(ACT_GET, k3, '0);
		send_word(ACT_DEL, k3, '0);
		send_word(ACT_GET, k3, '0);
	endtask

	// All-ones key and value, and a key with only the top bit set.
	task automatic test_extreme_words();
		send_word(ACT_PUT, '1, '1);
		send_word(ACT_GET, '1, '0);
		send_word(ACT_DEL, '1, '1);
		send_word(ACT_GET, '1, '0);
		send_word(ACT_PUT, 64'h8000_0000_0000_0000, 64'h1);
		send_word(ACT_GET, 64'h8000_0000_0000_0000, '0);
	endtask

	// Mostly traffic on a small pool of keys crowded into a few sets, so that sets fill,
	// keys conflict and deletes free slots; the rest is random keys and zero fields.
	task automatic test_random_traffic(input int count, input bit no_idle);
		logic [KEY_W-1:0] pool_key [POOL];
		logic [VAL_W-1:0] pool_val [POOL];
		int hot [3];
		int pick;
		int roll;
		logic [ACT_W-1:0] act;
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		steady = no_idle;
		for (int n = 0; n < count; n++) begin
			if (n % 250 == 0) begin
				foreach (hot[h])
					hot[h] = $urandom_range(SETS - 1);
				foreach (pool_key[i]) begin
					pool_key[i] = set_key(hot[i % 3]);
					pool_val[i] = rand_word();
				end
			end
			pick = $urandom_range(POOL - 1);
			roll = $urandom_range(99);
			if (roll < 45)
				act = ACT_PUT;
			else if (roll < 75)
				act = ACT_GET;
			else if (roll < 97)
				act = ACT_DEL;
			else
				act = ACT_NOP;
			roll = $urandom_range(99);
			if (roll < 86)
				k = pool_key[pick];
			else if (roll < 98)
				k = rand_word();
			else
				k = '0;
			roll = $urandom_range(99);
			if (roll < 55)
				v = pool_val[pick];
			else if (roll < 97)
				v = rand_word();
			else
				v = '0;
			send_word(act, k, v);
		end
		steady = 1'b0;
	endtask

	// Compare each accepted response word with the oldest expectation; stall at random except in steady traffic.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: response with none expected, status %0d value %h",
					$time, rsp.status, rsp.read_value);
				n_errors++;
			end else begin
				want_rsp = pending_rsp.pop_front();
				n_checked++;
				status_seen[want_rsp.status]++;
				if (rsp.status !== want_rsp.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, want_rsp.status, rsp.status);
					n_errors++;
				end
				if (rsp.read_value !== want_rsp.read_value) begin
					$display("%0t: read_value expected %h, got %h",
						$time, want_rsp.read_value, rsp.read_value);
					n_errors++;
				end
			end
		end
		rsp_stall <= !steady && ($urandom_range(99) < 6);
	end

	// Main sequence: reset, directed checks, then random traffic with a full drain after the first phase and at the end.
	initial begin
		logic [KEY_W-1:0] first_key;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		foreach (shadow_key[i]) begin
			shadow_key[i] = '0;
			shadow_val[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_rejects();
		test_put_rules(first_key);
		test_set_reuse(first_key);
		test_extreme_words();
		test_random_traffic(700, 1'b0);
		wait_drain();
		test_random_traffic(350, 1'b1);
		test_random_traffic(700, 1'b0);

		wait_drain();
		repeat (TAIL) @(posedge clk);

		$display("tb_top: %0d requests sent, %0d responses checked", n_sent, n_checked);
		$display("tb_top: ok %0d, not found %0d, conflict %0d, full %0d, rejected %0d",
			status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_CONFLICT],
			status_seen[ST_FULL], status_seen[ST_ZERO]);
		if (n_errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(5_000_000);
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
